// File: src/jse_pkg.sv
// Shared types and character constants for the JSON string escaper.
// No dependencies; used by jse_expand and json_string_escaper_unit.
package jse_pkg;

    localparam int unsigned RunMax = 8;
    localparam int unsigned IdxW   = $clog2(RunMax);

    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChB     = 8'h62;
    localparam logic [7:0] ChT     = 8'h74;
    localparam logic [7:0] ChN     = 8'h6E;
    localparam logic [7:0] ChF     = 8'h66;
    localparam logic [7:0] ChR     = 8'h72;
    localparam logic [7:0] ChU     = 8'h75;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChUpA   = 8'h41;

    // Control bytes with a short escape form, and the first byte above the control range
    localparam logic [7:0] CtlBs    = 8'h08;
    localparam logic [7:0] CtlTab   = 8'h09;
    localparam logic [7:0] CtlLf    = 8'h0A;
    localparam logic [7:0] CtlFf    = 8'h0C;
    localparam logic [7:0] CtlCr    = 8'h0D;
    localparam logic [7:0] CtlSpace = 8'h20;

    typedef struct packed {
        logic [7:0] ch;
        logic       first_char;
        logic       last_char;
        logic       empty_string;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_word;

    // Expanded output run for one input word
    typedef struct packed {
        logic [RunMax-1:0][7:0] bytes;
        logic [IdxW-1:0]        last_idx;
    } t_run;

endpackage

// File: src/json_string_escaper_unit.sv
// JSON string escaper top level: input register, run expansion, output register.
// Depends on jse_pkg and jse_expand.
//
// Usage: one raw string byte per input word (i_in_word) with first/last flags,
// or an empty_string word that yields two quotes. Each input word produces a
// run of 1 to 8 output words (o_out_word); the final word of a run carries
// last_of_run. Both channels are valid/stall: a word moves on a rising edge
// with valid high and stall low.
// The first output word of a run passes through the input register, then the
// output register. Throughput: one output word per cycle while the receiver
// does not stall. An input word holds the input register until the last
// byte of its run is loaded, so plain bytes flow at one per cycle and
// escapes stall the input. The output register drives the run from the
// input register through a 3-bit byte index.
// Reset (synchronous, active low) empties both registers and clears the index.
// When the receiver stalls, the output word holds, the index stops, and the
// input stalls once its register is occupied.
module json_string_escaper_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  jse_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output jse_pkg::t_out_word  o_out_word
);

    logic                     r_in_valid, n_in_valid;
    jse_pkg::t_in_word        r_in_word;
    logic [jse_pkg::IdxW-1:0] r_idx, n_idx;
    logic                     r_out_valid, n_out_valid;
    jse_pkg::t_out_word       r_out_word, n_out_word;
    jse_pkg::t_run            run;
    logic                     load;
    logic                     done;

    jse_expand u_expand (
        .i_word (r_in_word),
        .o_run  (run)
    );

    assign load       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign done       = load && (r_idx == run.last_idx);
    assign o_in_stall = r_in_valid && !done;

    always_comb begin
        n_in_valid  = o_in_stall ? r_in_valid : i_in_valid;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        if (load) begin
            n_idx                  = done ? '0 : r_idx + jse_pkg::IdxW'(1);
            n_out_valid            = 1'b1;
            n_out_word.out_byte    = run.bytes[r_idx];
            n_out_word.last_of_run = done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_idx_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> r_in_valid)
        else $error("byte index advanced with no input word held");

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (r_idx <= run.last_idx))
        else $error("byte index past end of run");

    a_done_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (r_idx == '0))
        else $error("byte index not rewound after run end");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_out_word.last_of_run == (r_idx == '0)))
        else $error("last_of_run disagrees with run completion");

endmodule

// File: src/jse_expand.sv
// Combinational expansion of one input word into its quoted, escaped byte run.
// Depends on jse_pkg.
module jse_expand (
    input  jse_pkg::t_in_word i_word,
    output jse_pkg::t_run     o_run
);

    logic [jse_pkg::RunMax-1:0][7:0] esc;
    logic [jse_pkg::IdxW-1:0]        esc_last;
    logic [7:0]                      sub;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        hex_digit = (v < 4'd10) ? (jse_pkg::ChZero + {4'd0, v})
                                : (jse_pkg::ChUpA + {4'd0, v} - 8'd10);
    endfunction

    always_comb begin
        case (i_word.ch)
            jse_pkg::CtlBs:    sub = jse_pkg::ChB;
            jse_pkg::CtlTab:   sub = jse_pkg::ChT;
            jse_pkg::CtlLf:    sub = jse_pkg::ChN;
            jse_pkg::CtlFf:    sub = jse_pkg::ChF;
            jse_pkg::CtlCr:    sub = jse_pkg::ChR;
            jse_pkg::ChQuote:  sub = jse_pkg::ChQuote;
            jse_pkg::ChBslash: sub = jse_pkg::ChBslash;
            default:           sub = 8'h00;
        endcase
    end

    // Escape body without quotes
    always_comb begin
        esc = '0;
        if (sub != 8'h00) begin
            esc[0]   = jse_pkg::ChBslash;
            esc[1]   = sub;
            esc_last = jse_pkg::IdxW'(1);
        end else if (i_word.ch < jse_pkg::CtlSpace) begin
            esc[0]   = jse_pkg::ChBslash;
            esc[1]   = jse_pkg::ChU;
            esc[2]   = jse_pkg::ChZero;
            esc[3]   = jse_pkg::ChZero;
            esc[4]   = hex_digit(i_word.ch[7:4]);
            esc[5]   = hex_digit(i_word.ch[3:0]);
            esc_last = jse_pkg::IdxW'(5);
        end else begin
            esc[0]   = i_word.ch;
            esc_last = '0;
        end
    end

    always_comb begin
        logic [jse_pkg::IdxW-1:0] k;
        for (int p = 0; p < jse_pkg::RunMax; p++) begin
            k = jse_pkg::IdxW'(p) - jse_pkg::IdxW'(i_word.first_char);
            if (i_word.empty_string || (i_word.first_char && p == 0) || k > esc_last) begin
                o_run.bytes[p] = jse_pkg::ChQuote;
            end else begin
                o_run.bytes[p] = esc[k];
            end
        end
        if (i_word.empty_string) begin
            o_run.last_idx = jse_pkg::IdxW'(1);
        end else begin
            o_run.last_idx = esc_last + jse_pkg::IdxW'(i_word.first_char)
                           + jse_pkg::IdxW'(i_word.last_char);
        end
    end

endmodule
